FILE: hw/rtl/bbtd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbtd_pkg
// Shared types, constants and the byte-to-unicode inverse map for the
// byte-level token decoder.
// ----------------------------------------------------------------------------
package bbtd_pkg;

    // sizes
    localparam int unsigned GRP_MAX     = 4;   // most result bytes per input item
    localparam int unsigned GRP_CNT_W   = 3;   // holds 0..GRP_MAX
    localparam int unsigned GRP_IDX_W   = 2;   // indexes 0..GRP_MAX-1
    localparam int unsigned PEND_MAX    = 3;   // pending bytes of an open sequence
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    // utf-8 class masks
    localparam logic [7:0] LEAD2_MASK = 8'he0;
    localparam logic [7:0] LEAD2_VAL  = 8'hc0;
    localparam logic [7:0] LEAD3_MASK = 8'hf0;
    localparam logic [7:0] LEAD3_VAL  = 8'he0;
    localparam logic [7:0] LEAD4_MASK = 8'hf8;
    localparam logic [7:0] LEAD4_VAL  = 8'hf0;
    localparam logic [7:0] CONT_MASK  = 8'hc0;
    localparam logic [7:0] CONT_VAL   = 8'h80;

    // inverse map ranges
    localparam logic [7:0] DIRECT_A_LO = 8'd33;
    localparam logic [7:0] DIRECT_A_HI = 8'd126;
    localparam logic [7:0] DIRECT_B_LO = 8'd161;
    localparam logic [7:0] DIRECT_B_HI = 8'd172;
    localparam logic [7:0] DIRECT_C_LO = 8'd174;
    localparam logic [7:0] EXTRA_LOW_HI  = 8'd32;  // 256..288 -> 0..32
    localparam logic [7:0] EXTRA_MID_HI  = 8'd66;  // 289..322 -> 127..160
    localparam logic [7:0] EXTRA_MID_ADD = 8'd94;  // 127 - 33
    localparam logic [7:0] EXTRA_SOFT    = 8'd67;  // 323 -> 173
    localparam logic [7:0] SOFT_HYPHEN   = 8'd173;

    // one input item's worth of result bytes
    typedef struct packed {
        logic [GRP_MAX-1:0][7:0] data;
        logic [GRP_CNT_W-1:0]    cnt;
        logic                    last;
    } group_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } map_t;

    // inverse of the byte-to-unicode table for code points below 512
    function automatic map_t inv_map(input logic [8:0] cp);
        map_t       r;
        logic [7:0] w;
        begin
            w = cp[7:0];
            r.hit   = 1'b0;
            r.value = w;
            if (!cp[8]) begin
                r.hit = ((w >= DIRECT_A_LO) && (w <= DIRECT_A_HI)) ||
                        ((w >= DIRECT_B_LO) && (w <= DIRECT_B_HI)) ||
                        (w >= DIRECT_C_LO);
            end else if (w <= EXTRA_LOW_HI) begin
                r.hit = 1'b1;
            end else if (w <= EXTRA_MID_HI) begin
                r.hit   = 1'b1;
                r.value = w + EXTRA_MID_ADD;
            end else if (w == EXTRA_SOFT) begin
                r.hit   = 1'b1;
                r.value = SOFT_HYPHEN;
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/byte_level_bpe_token_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_level_bpe_token_decoder
// Turns the utf-8 text bytes of a token back into its original bytes.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries one text byte per item (in_byte)
// with in_last on the final byte of a token. Output channel
// out_valid/out_stall carries one decoded byte per item with out_last on the
// final byte of the token's output.
// An input item can be taken every cycle while in_stall is low. Each item
// yields zero to four output bytes; the back end drains one byte per cycle
// unless out_stall holds it, each byte via the queue and output register.
// A four-entry group queue separates the classifier from the output walker;
// in_stall is high only while that queue is full.
// Stalling the output holds out_byte/out_last steady and lets the queue fill
// up, after which the input is stalled as well. Nothing is dropped.
// Reset empties the queue and output register and clears the open sequence.
// ----------------------------------------------------------------------------
module byte_level_bpe_token_decoder
    import bbtd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            out_last
);

    logic   q_full;
    logic   q_empty;
    logic   push;
    logic   pop;
    group_t push_grp;
    group_t head;

    assign in_stall = q_full;

    // classifier and pending state
    bbtd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .q_full   (q_full),
        .push     (push),
        .push_grp (push_grp)
    );

    // group queue
    bbtd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_grp (push_grp),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    // output walker
    bbtd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/bbtd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbtd_front
// Accepts input bytes, tracks the open utf-8 sequence and turns each item
// into a group of zero to four result bytes for the queue.
// ----------------------------------------------------------------------------
module bbtd_front
    import bbtd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire logic       q_full,
    output logic            push,
    output group_t          push_grp
);

    logic [1:0]               cnt_reg;
    logic [1:0]               cnt_next;
    logic [PEND_MAX-1:0][7:0] pend_reg;
    logic [PEND_MAX-1:0][7:0] pend_next;

    logic        accept;
    logic        in_is_lead;
    logic        in_is_cont;
    logic        lead2;
    logic        lead3;
    logic [2:0]  need;
    logic        seq_done;
    logic [20:0] cp;
    map_t        mapped;
    group_t      grp;
    logic [2:0]  n;

    assign accept = in_valid && !q_full;

    // classify the incoming byte
    assign in_is_lead = ((in_byte & LEAD2_MASK) == LEAD2_VAL) ||
                        ((in_byte & LEAD3_MASK) == LEAD3_VAL) ||
                        ((in_byte & LEAD4_MASK) == LEAD4_VAL);
    assign in_is_cont = ((in_byte & CONT_MASK) == CONT_VAL);

    // sequence length from the stored lead byte
    assign lead2 = ((pend_reg[0] & LEAD2_MASK) == LEAD2_VAL);
    assign lead3 = ((pend_reg[0] & LEAD3_MASK) == LEAD3_VAL);
    assign need  = lead2 ? 3'd2 : (lead3 ? 3'd3 : 3'd4);
    assign seq_done = ({1'b0, cnt_reg} + 3'd1) >= need;

    // code point of the sequence completed by this byte
    always_comb
    begin
        if (lead2)
        begin
            cp = {10'd0, pend_reg[0][4:0], in_byte[5:0]};
        end
        else if (lead3)
        begin
            cp = {5'd0, pend_reg[0][3:0], pend_reg[1][5:0], in_byte[5:0]};
        end
        else
        begin
            cp = {pend_reg[0][2:0], pend_reg[1][5:0], pend_reg[2][5:0], in_byte[5:0]};
        end
    end

    always_comb
    begin
        mapped = inv_map(cp[8:0]);
        if (cp[20:9] != 12'd0)
        begin
            mapped.hit = 1'b0;
        end
    end

    // build the result group and the next pending state
    always_comb
    begin
        grp       = '0;
        n         = '0;
        cnt_next  = cnt_reg;
        pend_next = pend_reg;
        if (cnt_reg == 2'd0)
        begin
            if (in_is_lead)
            begin
                pend_next[0] = in_byte;
                cnt_next     = 2'd1;
            end
            else
            begin
                grp.data[n[1:0]] = in_byte;
                n = n + 3'd1;
            end
        end
        else if (in_is_cont)
        begin
            if (seq_done)
            begin
                if (mapped.hit)
                begin
                    grp.data[n[1:0]] = mapped.value;
                    n = n + 3'd1;
                end
                else
                begin
                    // no map entry: raw bytes pass through
                    for (int i = 0; i < PEND_MAX; i++)
                    begin
                        if (2'(i) < cnt_reg)
                        begin
                            grp.data[n[1:0]] = pend_reg[i];
                            n = n + 3'd1;
                        end
                    end
                    grp.data[n[1:0]] = in_byte;
                    n = n + 3'd1;
                end
                cnt_next = 2'd0;
            end
            else
            begin
                pend_next[cnt_reg] = in_byte;
                cnt_next = cnt_reg + 2'd1;
            end
        end
        else
        begin
            // broken sequence: flush raw, then restart with this byte
            for (int i = 0; i < PEND_MAX; i++)
            begin
                if (2'(i) < cnt_reg)
                begin
                    grp.data[n[1:0]] = pend_reg[i];
                    n = n + 3'd1;
                end
            end
            cnt_next = 2'd0;
            if (in_is_lead)
            begin
                pend_next[0] = in_byte;
                cnt_next     = 2'd1;
            end
            else
            begin
                grp.data[n[1:0]] = in_byte;
                n = n + 3'd1;
            end
        end
        // end of token: flush what is still pending
        if (in_last)
        begin
            for (int i = 0; i < PEND_MAX; i++)
            begin
                if (2'(i) < cnt_next)
                begin
                    grp.data[n[1:0]] = pend_next[i];
                    n = n + 3'd1;
                end
            end
            cnt_next = 2'd0;
        end
        grp.cnt  = n;
        grp.last = in_last;
    end

    assign push     = accept && (n != 3'd0);
    assign push_grp = grp;

    // pending count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (accept)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // pending bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/bbtd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbtd_queue
// Short fifo of result groups between the front and the back.
// ----------------------------------------------------------------------------
module bbtd_queue
    import bbtd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire group_t push_grp,
    input  wire logic   pop,
    output logic        full,
    output logic        empty,
    output group_t      head
);

    group_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_grp;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/bbtd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbtd_back
// Walks the head group one byte at a time into the output register.
// ----------------------------------------------------------------------------
module bbtd_back
    import bbtd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_empty,
    input  wire group_t head,
    output logic        pop,
    output logic        out_valid,
    input  wire logic   out_stall,
    output logic [7:0]  out_byte,
    output logic        out_last
);

    logic [GRP_IDX_W-1:0] idx_reg;
    logic [GRP_IDX_W-1:0] idx_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic [7:0]           byte_reg;
    logic [7:0]           byte_next;
    logic                 last_reg;
    logic                 last_next;
    logic                 load;
    logic                 at_end;

    assign load   = !valid_reg || !out_stall;
    assign at_end = ({1'b0, idx_reg} == (head.cnt - GRP_CNT_W'(1)));
    assign pop    = load && !q_empty && at_end;

    // next output byte from the head group
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = !q_empty;
            if (!q_empty)
            begin
                byte_next = head.data[idx_reg];
                last_next = head.last && at_end;
                idx_next  = at_end ? '0 : idx_reg + GRP_IDX_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

endmodule
`default_nettype wire

FILE: tb/sv/byte_level_bpe_token_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_level_bpe_token_decoder_tb
// Streams token text bytes through the decoder and checks every decoded byte
// against an in-bench utf-8 / byte-map predictor. It starts with a short
// directed set, then runs random tokens built from mapped, raw, broken and
// truncated sequences. Both sides idle at random, with one long output stall.
// ----------------------------------------------------------------------------
module byte_level_bpe_token_decoder_tb
    import bbtd_pkg::*;
();

    localparam int unsigned RANDOM_ITEMS = 400;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned HOLD_START   = 150;
    localparam int unsigned HOLD_CYCLES  = 200;

    typedef struct packed {
        logic [7:0] b;
        logic       l;
    } text_item_t;

    typedef struct packed {
        logic [7:0] b;
        logic       l;
    } dec_byte_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       out_last;

    // stimulus and expected output
    text_item_t  text_q[$];
    dec_byte_t   decoded_q[$];
    logic [7:0]  step_out[$];

    // predictor state: bytes of the open utf-8 sequence
    logic [7:0]  utf_pend[0:2];
    int unsigned utf_cnt = 0;

    int unsigned sent_cnt = 0;
    int unsigned taken_cnt = 0;
    int unsigned token_cnt = 0;
    int unsigned out_cnt = 0;
    int unsigned err_cnt = 0;
    int unsigned send_gap = 0;
    int unsigned recv_gap = 0;
    int unsigned hold_left = 0;
    int unsigned in_blocked = 0;
    int unsigned idle_cycles = 0;
    bit          hold_done = 1'b0;

    byte_level_bpe_token_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // sequence length from a lead byte
    function automatic int unsigned seq_len(input logic [7:0] lead);
        if ((lead & LEAD2_MASK) == LEAD2_VAL)
            return 2;
        if ((lead & LEAD3_MASK) == LEAD3_VAL)
            return 3;
        if ((lead & LEAD4_MASK) == LEAD4_VAL)
            return 4;
        return 1;
    endfunction

    // code point back to its original byte, {hit, byte}
    function automatic logic [8:0] unmap_cp(input logic [20:0] cp);
        if (cp >= 21'd512)
            return 9'h000;
        // printable ranges map onto themselves
        if ((cp >= 21'd33 && cp <= 21'd126) || (cp >= 21'd161 && cp <= 21'd172) ||
            (cp >= 21'd174 && cp <= 21'd255))
            return {1'b1, cp[7:0]};
        // shifted control and blank bytes
        if (cp >= 21'd256 && cp <= 21'd288)
            return {1'b1, cp[7:0]};
        if (cp >= 21'd289 && cp <= 21'd322)
            return {1'b1, cp[7:0] + 8'd94};
        if (cp == 21'd323)
            return {1'b1, 8'd173};
        return 9'h000;
    endfunction

    // pending bytes go out raw
    task automatic flush_pending();
        for (int i = 0; i < utf_cnt; i++)
            step_out.push_back(utf_pend[i]);
        utf_cnt = 0;
    endtask

    // a lead byte opens a sequence, anything else passes as itself
    task automatic open_or_pass(input logic [7:0] b);
        if (seq_len(b) > 1)
        begin
            utf_pend[0] = b;
            utf_cnt = 1;
        end
        else
        begin
            step_out.push_back(b);
        end
    endtask

    // predict the decoded bytes for one accepted text byte
    task automatic decode_byte(input logic [7:0] b, input logic l);
        int unsigned need;
        logic [20:0] cp;
        logic [8:0]  hit_val;
        dec_byte_t   d;
        step_out.delete();
        if (utf_cnt == 0)
        begin
            open_or_pass(b);
        end
        else if ((b & CONT_MASK) == CONT_VAL)
        begin
            need = seq_len(utf_pend[0]);
            if (utf_cnt + 1 >= need)
            begin
                // sequence complete: build the code point
                if (need == 2)
                    cp = 21'(utf_pend[0] & 8'h1f);
                else if (need == 3)
                    cp = 21'(utf_pend[0] & 8'h0f);
                else
                    cp = 21'(utf_pend[0] & 8'h07);
                for (int i = 1; i < utf_cnt; i++)
                    cp = (cp << 6) | 21'(utf_pend[i] & 8'h3f);
                cp = (cp << 6) | 21'(b & 8'h3f);
                hit_val = unmap_cp(cp);
                if (hit_val[8])
                begin
                    step_out.push_back(hit_val[7:0]);
                    utf_cnt = 0;
                end
                else
                begin
                    flush_pending();
                    step_out.push_back(b);
                end
            end
            else
            begin
                utf_pend[utf_cnt] = b;
                utf_cnt++;
            end
        end
        else
        begin
            // broken sequence
            flush_pending();
            open_or_pass(b);
        end
        // truncated token
        if (l)
            flush_pending();
        for (int i = 0; i < step_out.size(); i++)
        begin
            d.b = step_out[i];
            d.l = l && (i == step_out.size() - 1);
            decoded_q.push_back(d);
        end
    endtask

    task automatic add_text(input logic [7:0] b, input logic l);
        text_item_t t;
        t.b = b;
        t.l = l;
        text_q.push_back(t);
    endtask

    // random lead byte opening a sequence of the given length
    function automatic logic [7:0] lead_for(input int unsigned len);
        logic [7:0] r;
        r = 8'($urandom);
        if (len == 2)
            return (r & ~LEAD2_MASK) | LEAD2_VAL;
        if (len == 3)
            return (r & ~LEAD3_MASK) | LEAD3_VAL;
        return (r & ~LEAD4_MASK) | LEAD4_VAL;
    endfunction

    function automatic logic [7:0] rand_cont();
        logic [7:0] r;
        r = 8'($urandom);
        return (r & ~CONT_MASK) | CONT_VAL;
    endfunction

    // one random token of one to four pieces
    task automatic make_token();
        logic [7:0]  tok[$];
        logic [15:0] cp;
        int unsigned kind;
        int unsigned len;
        int unsigned conts;
        repeat ($urandom_range(1, 4))
        begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1: tok.push_back(8'($urandom_range(1, 127)));
                2, 3:
                begin
                    // two byte form of a code point near the byte map
                    cp = 16'($urandom_range(33, 323));
                    tok.push_back({3'b110, cp[10:6]});
                    tok.push_back({2'b10, cp[5:0]});
                end
                4:
                begin
                    // overlong three byte form
                    cp = 16'($urandom_range(33, 323));
                    tok.push_back({4'b1110, cp[15:12]});
                    tok.push_back({2'b10, cp[11:6]});
                    tok.push_back({2'b10, cp[5:0]});
                end
                5, 6, 7:
                begin
                    len = kind - 3;
                    tok.push_back(lead_for(len));
                    repeat (len - 1)
                        tok.push_back(rand_cont());
                end
                8:
                begin
                    // sequence cut short
                    len = $urandom_range(2, 4);
                    conts = $urandom_range(0, len - 2);
                    tok.push_back(lead_for(len));
                    repeat (conts)
                        tok.push_back(rand_cont());
                end
                default: tok.push_back(8'($urandom_range(1, 255)));
            endcase
        end
        for (int i = 0; i < tok.size(); i++)
            add_text(tok[i], i == tok.size() - 1);
    endtask

    // idle cycles before the next item, varied in stretches of items
    function automatic int unsigned draw_gap(input int unsigned n);
        case ((n / 50) % 3)
            0: return 0;
            1: return $urandom_range(0, 13);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
        endcase
    endfunction

    // input driver
    always @(posedge clk or negedge rst_n)
    begin : drive
        text_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_byte  <= 8'h00;
            in_last  <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                decode_byte(in_byte, in_last);
                taken_cnt <= taken_cnt + 1;
                if (in_last)
                    token_cnt <= token_cnt + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (text_q.size() != 0)
                begin
                    nxt = text_q.pop_front();
                    in_valid <= 1'b1;
                    in_byte  <= nxt.b;
                    in_last  <= nxt.l;
                    sent_cnt <= sent_cnt + 1;
                    // keep offering back to back around the long output stall
                    if (sent_cnt >= HOLD_START - 10 && sent_cnt < HOLD_START + 110)
                        send_gap <= 0;
                    else
                        send_gap <= draw_gap(sent_cnt);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin : receive
        dec_byte_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (decoded_q.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, actual byte %02h last %0b",
                             $time, out_byte, out_last);
                    err_cnt++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (out_byte !== want.b)
                    begin
                        $display("%0t: out_byte mismatch, expected %02h actual %02h",
                                 $time, want.b, out_byte);
                        err_cnt++;
                    end
                    if (out_last !== want.l)
                    begin
                        $display("%0t: out_last mismatch, expected %0b actual %0b",
                                 $time, want.l, out_last);
                        err_cnt++;
                    end
                end
                out_cnt++;
                recv_gap = draw_gap(out_cnt);
            end
            // one long hold-off so the block backs up into its input
            if (!hold_done && taken_cnt >= HOLD_START)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (recv_gap != 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_stall)
                in_blocked++;
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT)
                begin
                    $display("%0t: no progress for %0d cycles, %0d items still expected",
                             $time, idle_cycles, decoded_q.size());
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        int unsigned directed_cnt;
        rst_n = 1'b0;

        // ascii, low and high single bytes, stray continuation
        add_text(8'h41, 1'b1);
        add_text(8'h01, 1'b0);
        add_text(8'hff, 1'b0);
        add_text(8'h80, 1'b1);
        // mapped two byte forms: byte 0 and the soft hyphen
        add_text(8'hc4, 1'b0);
        add_text(8'h80, 1'b1);
        add_text(8'hc5, 1'b0);
        add_text(8'h83, 1'b1);
        // first code point past the map passes raw
        add_text(8'hc5, 1'b0);
        add_text(8'h84, 1'b1);
        // three byte sequence outside the map
        add_text(8'he2, 1'b0);
        add_text(8'h82, 1'b0);
        add_text(8'hac, 1'b1);
        // four byte sequence: four raw bytes from one item
        add_text(8'hf0, 1'b0);
        add_text(8'h9f, 1'b0);
        add_text(8'h98, 1'b0);
        add_text(8'h80, 1'b1);
        // broken sequence, then a truncated one at the end of the token
        add_text(8'hc4, 1'b0);
        add_text(8'h41, 1'b0);
        add_text(8'he2, 1'b0);
        add_text(8'h82, 1'b1);
        // lead after lead, then a completed mapped pair
        add_text(8'hc4, 1'b0);
        add_text(8'hc4, 1'b0);
        add_text(8'ha0, 1'b1);
        // lone lead byte closing a token
        add_text(8'hf4, 1'b1);
        directed_cnt = text_q.size();

        while (text_q.size() < directed_cnt + RANDOM_ITEMS)
            make_token();

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        while (text_q.size() != 0 || in_valid || decoded_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d tokens: %0d text bytes in, %0d decoded bytes out",
                 token_cnt, taken_cnt, out_cnt);
        $display("output held off %0d cycles once; input stalled %0d cycles in total",
                 HOLD_CYCLES, in_blocked);
        if (err_cnt == 0 && decoded_q.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
